>>> rtl/ale_pkg.sv
// shared types and constants for the array list engine
package ale_pkg;

  // field widths of the request and result ports
  localparam int unsigned DATA_W = 32;
  localparam int unsigned KIND_W = 4;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned REM_W  = 5;
  localparam int unsigned LEN_W  = 5;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INS_HEAD  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_INS_TAIL  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_INS_AFTER = 4'd2;
  localparam logic [KIND_W-1:0] KIND_DEL_HEAD  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_DEL_TAIL  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_DEL_MATCH = 4'd5;
  localparam logic [KIND_W-1:0] KIND_DEL_ALL   = 4'd6;
  localparam logic [KIND_W-1:0] KIND_SEARCH    = 4'd7;
  localparam logic [KIND_W-1:0] KIND_READ_HEAD = 4'd8;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_SHR_RD,
    ST_SHR_WR,
    ST_PUT,
    ST_SHL_RD,
    ST_SHL_WR,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_DONE
  } ale_state_t;

endpackage

>>> rtl/ale_store.sv
// entry memory with registered read and a copy of the head entry
module ale_store import ale_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr,
  output logic signed [DATA_W-1:0]  rd_data,
  input  logic                      wr_en,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  logic signed [DATA_W-1:0]  wr_data,
  output logic signed [DATA_W-1:0]  head
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // head copy follows every write to the first slot
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == '0)) begin
      head <= wr_data;
    end
  end

endmodule

>>> rtl/array_list_engine.sv
// array list engine: ordered list of signed words with a small sequencer
//
// A request is taken on a clock edge where start is high and busy is low;
// kind selects the operation, value and key are its operands. The engine
// then walks its entry memory one entry at a time and raises done for
// exactly one cycle with the result on success, found, position,
// removed_count, head_value and length. The receiver cannot stall: done is
// not held, but the result fields keep their values until the next request
// is accepted. busy stays high from the accepting edge through the done cycle.
// Delete tail, read head, unused codes, inserts rejected as full and delete
// head on an empty list finish without touching the memory. The worst case
// is a scan of a full list. The pace is set by the single memory port pair:
// one read, then a compare or a write, per entry.
// Reset empties the list at once; entry contents are not cleared.
module array_list_engine import ale_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [KIND_W-1:0]        kind,
  input  logic signed [DATA_W-1:0] value,
  input  logic signed [DATA_W-1:0] key,
  output logic                     done,
  output logic                     success,
  output logic                     found,
  output logic [POS_W-1:0]         position,
  output logic [REM_W-1:0]         removed_count,
  output logic signed [DATA_W-1:0] head_value,
  output logic [LEN_W-1:0]         length
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ale_state_t state, state_next;

  logic [CW-1:0]            cnt, cnt_next;
  logic [CW-1:0]            idx, idx_next;
  logic [CW-1:0]            aux, aux_next;
  logic [CW-1:0]            removed, removed_next;
  logic [IW-1:0]            pos, pos_next;
  logic                     succ, succ_next;
  logic                     hit, hit_next;
  logic [KIND_W-1:0]        kind_q, kind_next;
  logic signed [DATA_W-1:0] value_q, value_next;
  logic signed [DATA_W-1:0] key_q, key_next;

  logic                     rd_en, wr_en;
  logic [IW-1:0]            rd_addr, wr_addr;
  logic signed [DATA_W-1:0] rd_data, wr_data, head;

  logic [CW-1:0] idx_p1, idx_m1;
  logic          full;

  assign idx_p1 = idx + CW'(1);
  assign idx_m1 = idx - CW'(1);
  assign full   = (cnt == CW'(DEPTH));

  // entry memory
  ale_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .head   (head)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // working registers and result fields
  always_ff @(posedge clk) begin
    idx     <= idx_next;
    aux     <= aux_next;
    removed <= removed_next;
    pos     <= pos_next;
    succ    <= succ_next;
    hit     <= hit_next;
    kind_q  <= kind_next;
    value_q <= value_next;
    key_q   <= key_next;
  end

  // sequencer: next state, memory controls
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    idx_next     = idx;
    aux_next     = aux;
    removed_next = removed;
    pos_next     = pos;
    succ_next    = succ;
    hit_next     = hit;
    kind_next    = kind_q;
    value_next   = value_q;
    key_next     = key_q;
    rd_en        = 1'b0;
    rd_addr      = idx[IW-1:0];
    wr_en        = 1'b0;
    wr_addr      = idx[IW-1:0];
    wr_data      = rd_data;

    case (state)
      ST_IDLE: begin
        if (start) begin
          kind_next    = kind;
          value_next   = value;
          key_next     = key;
          succ_next    = 1'b0;
          hit_next     = 1'b0;
          pos_next     = '0;
          removed_next = '0;
          idx_next     = '0;
          aux_next     = '0;
          case (kind)
            KIND_INS_HEAD: begin
              if (full) begin
                state_next = ST_DONE;
              end else begin
                idx_next   = cnt;
                state_next = ST_SHR_RD;
              end
            end
            KIND_INS_TAIL: begin
              if (full) begin
                state_next = ST_DONE;
              end else begin
                idx_next   = cnt;
                aux_next   = cnt;
                state_next = ST_SHR_RD;
              end
            end
            KIND_INS_AFTER: begin
              state_next = full ? ST_DONE : ST_FIND_RD;
            end
            KIND_DEL_HEAD: begin
              state_next = (cnt == '0) ? ST_DONE : ST_SHL_RD;
            end
            KIND_DEL_TAIL: begin
              if (cnt != '0) begin
                cnt_next  = cnt - CW'(1);
                succ_next = 1'b1;
              end
              state_next = ST_DONE;
            end
            KIND_DEL_MATCH, KIND_SEARCH: begin
              state_next = ST_FIND_RD;
            end
            KIND_DEL_ALL: begin
              state_next = ST_CMP_RD;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end

      // scan for the first entry equal to key
      ST_FIND_RD: begin
        if (idx == cnt) begin
          state_next = ST_DONE;
        end else begin
          rd_en      = 1'b1;
          state_next = ST_FIND_CMP;
        end
      end
      ST_FIND_CMP: begin
        if (rd_data == key_q) begin
          case (kind_q)
            KIND_INS_AFTER: begin
              aux_next   = idx_p1;
              idx_next   = cnt;
              state_next = ST_SHR_RD;
            end
            KIND_DEL_MATCH: begin
              state_next = ST_SHL_RD;
            end
            default: begin
              hit_next   = 1'b1;
              pos_next   = idx[IW-1:0];
              state_next = ST_DONE;
            end
          endcase
        end else begin
          idx_next   = idx_p1;
          state_next = ST_FIND_RD;
        end
      end

      // open a slot at aux by moving entries up from the tail
      ST_SHR_RD: begin
        if (idx > aux) begin
          rd_en      = 1'b1;
          rd_addr    = idx_m1[IW-1:0];
          state_next = ST_SHR_WR;
        end else begin
          state_next = ST_PUT;
        end
      end
      ST_SHR_WR: begin
        wr_en      = 1'b1;
        idx_next   = idx_m1;
        state_next = ST_SHR_RD;
      end
      ST_PUT: begin
        wr_en      = 1'b1;
        wr_addr    = aux[IW-1:0];
        wr_data    = value_q;
        cnt_next   = cnt + CW'(1);
        succ_next  = 1'b1;
        state_next = ST_DONE;
      end

      // close the slot at idx by moving entries down
      ST_SHL_RD: begin
        if (idx_p1 < cnt) begin
          rd_en      = 1'b1;
          rd_addr    = idx_p1[IW-1:0];
          state_next = ST_SHL_WR;
        end else begin
          cnt_next   = cnt - CW'(1);
          succ_next  = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_SHL_WR: begin
        wr_en      = 1'b1;
        idx_next   = idx_p1;
        state_next = ST_SHL_RD;
      end

      // compaction: idx reads, aux writes survivors
      ST_CMP_RD: begin
        if (idx == cnt) begin
          cnt_next   = aux;
          succ_next  = (removed != '0);
          state_next = ST_DONE;
        end else begin
          rd_en      = 1'b1;
          state_next = ST_CMP_CHK;
        end
      end
      ST_CMP_CHK: begin
        if (rd_data == key_q) begin
          removed_next = removed + CW'(1);
        end else begin
          wr_en    = 1'b1;
          wr_addr  = aux[IW-1:0];
          aux_next = aux + CW'(1);
        end
        idx_next   = idx_p1;
        state_next = ST_CMP_RD;
      end

      ST_DONE: begin
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // result ports, narrow fields masked to their widths
  logic [IW+POS_W-1:0] pos_ext;
  logic [CW+REM_W-1:0] rem_ext;
  logic [CW+LEN_W-1:0] len_ext;

  assign pos_ext = {{POS_W{1'b0}}, pos};
  assign rem_ext = {{REM_W{1'b0}}, removed};
  assign len_ext = {{LEN_W{1'b0}}, cnt};

  assign busy          = (state != ST_IDLE);
  assign done          = (state == ST_DONE);
  assign success       = succ;
  assign found         = hit;
  assign position      = pos_ext[POS_W-1:0];
  assign removed_count = rem_ext[REM_W-1:0];
  assign length        = len_ext[LEN_W-1:0];
  assign head_value    = (cnt != '0) ? head : '1;

endmodule

>>> rtl/ale_checker.sv
// port-level checks for the array list engine, bound to the top level
module ale_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        success,
  input logic        found,
  input logic [4:0]  removed_count,
  input logic [4:0]  length,
  input logic [31:0] head_value
);

  // an accepted request makes the engine busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("engine not busy after accepting a request");

  // a result ends the request
  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("engine still busy after a result");

  // a search never reports a list change
  a_found_no_change: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> !success)
    else $error("found and success both set");

  // removing entries always counts as a success
  a_removed_success: assert property (@(posedge clk) disable iff (rst)
    (done && (removed_count != 5'd0)) |-> success)
    else $error("entries removed without success");

  // the list holds still while idle with no request
  a_idle_stable: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> ($stable(length) && $stable(head_value)))
    else $error("list status changed while idle");

endmodule

bind array_list_engine ale_checker u_ale_checker (.*);
